// File: rtl/atss_pkg.sv
// Shared types, constants and segment font for the temperature display scanner.
package atss_pkg;

  localparam int SAMPLE_BITS    = 10;
  localparam int DIGIT_COUNT    = 4;
  localparam int POS_BITS       = $clog2(DIGIT_COUNT);
  localparam int VALUE_BITS     = 16;
  localparam int TICK_BITS      = 16;
  localparam int SEG_BITS       = 8;
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 16;
  localparam int Q0_BITS        = 7;   // thousands quotient of a 16-bit value, up to 65
  localparam int BCD_BITS       = 4;
  localparam int REST_BITS      = 10;  // remainder below 1000
  localparam int R2_BITS        = 7;   // remainder below 100

  typedef logic [SAMPLE_BITS-1:0]    sample_t;
  typedef logic [VALUE_BITS-1:0]     value_t;
  typedef logic [TICK_BITS-1:0]      tick_t;
  typedef logic [POS_BITS-1:0]       pos_t;
  typedef logic [SEG_BITS-1:0]       seg_t;
  typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

  // Input kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  // Register indexes
  localparam cfg_index_t REG_REFRESH = cfg_index_t'(0);
  localparam cfg_index_t REG_DWELL   = cfg_index_t'(1);

  localparam tick_t REFRESH_RESET = tick_t'(500);
  localparam tick_t DWELL_RESET   = tick_t'(1);

  // 5 V full scale at 10 mV per degree, in hundredths of a degree
  localparam int FULL_SCALE = 50000;

  // Digit positions, leftmost first
  localparam pos_t POS_THOU = pos_t'(0);
  localparam pos_t POS_HUND = pos_t'(1);
  localparam pos_t POS_TENS = pos_t'(2);
  localparam pos_t POS_UNIT = pos_t'(3);

  // Reciprocal constants: floor(x / d) == (x * MUL) >> SHIFT over the range used
  localparam int THOU_MUL   = 67109;
  localparam int THOU_SHIFT = 26;
  localparam int HUND_MUL   = 41;
  localparam int HUND_SHIFT = 12;
  localparam int TEN_MUL    = 103;
  localparam int TEN_SHIFT  = 10;

  localparam seg_t SEG_DP = 8'h01;

  typedef struct packed {
    value_t value;
    pos_t   pos;
  } snap_t;

  typedef struct packed {
    value_t               value;
    pos_t                 pos;
    logic [Q0_BITS-1:0]   q0;
    logic [BCD_BITS-1:0]  q1;
    logic [BCD_BITS-1:0]  q2;
    logic [R2_BITS-1:0]   r2;
  } digits_t;

  // Segment font; bit0 DP, bit1 C, bit2 D, bit3 E, bit4 B, bit5 A, bit6 F, bit7 G
  function automatic seg_t glyph(input logic [Q0_BITS-1:0] d);
    seg_t s;
    case (d)
      7'd0:    s = 8'h7E;
      7'd1:    s = 8'h12;
      7'd2:    s = 8'hBC;
      7'd3:    s = 8'hB6;
      7'd4:    s = 8'hD2;
      7'd5:    s = 8'hE6;
      7'd6:    s = 8'hCE;
      7'd7:    s = 8'h32;
      7'd8:    s = 8'hFE;
      7'd9:    s = 8'hF2;
      default: s = 8'h00;  // anything above nine is blank
    endcase
    return s;
  endfunction

endpackage

// File: rtl/atss_if.sv
// Channel interfaces: sample/tick input, display result, register writes.
interface atss_in_if;
  logic                   valid;
  logic                   ready;
  logic                   kind;
  atss_pkg::sample_t      sample;
  modport source (output valid, output kind, output sample, input ready);
  modport sink   (input valid, input kind, input sample, output ready);
endinterface

interface atss_out_if;
  logic                        valid;
  logic                        ready;
  atss_pkg::seg_t              segments;
  logic [atss_pkg::DIGIT_COUNT-1:0] digit_select;
  atss_pkg::value_t            shown_value;
  modport source (output valid, output segments, output digit_select, output shown_value,
                  input ready);
  modport sink   (input valid, input segments, input digit_select, input shown_value,
                  output ready);
endinterface

interface atss_cfg_if;
  logic                                valid;
  logic                                ready;
  atss_pkg::cfg_index_t                index;
  logic [atss_pkg::CFG_DATA_BITS-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/adc_temperature_seven_segment_scan.sv
// Top level: temperature readout scanner for a multiplexed four-digit display.
//
// in_ch carries items of two kinds: kind 0 delivers a 10-bit ADC sample,
// kind 1 is one timer tick. Every accepted item yields exactly one result
// item on out_ch: segment lines, one-hot digit enable (bit0 = leftmost)
// and the displayed value in hundredths of a degree (XX.XX on the glass).
// cfg_ch writes refresh_ticks (index 0) and dwell_ticks (index 1); it is
// always ready, and indexes beyond those are dropped.
//
// Registered in order: state update, thousands split, hundreds split, tens
// split, glyph/output register. Throughput: one item per cycle unless
// out_ch stalls; the counters and the shown value live in a single
// register set updated at accept, so items may follow back to back. Each
// stage holds its item until the next is free, so a stalled out_ch fills
// the pipe and in_ch.ready drops only once all five stages are full.
//
// Reset (rst_n low, synchronous): registers return to 500 and 1, display
// value, counters and scan position clear to zero/leftmost, pipe empties.
// The first sample after reset latches the display at once.
module adc_temperature_seven_segment_scan (
  input  logic        clk,
  input  logic        rst_n,
  atss_in_if.sink     in_ch,
  atss_out_if.source  out_ch,
  atss_cfg_if.sink    cfg_ch
);

  logic                 snap_valid, snap_ready;
  atss_pkg::snap_t      snap;
  logic                 dig_valid, dig_ready;
  atss_pkg::digits_t    dig;

  // Event handling and the architectural state
  atss_state u_state (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .cfg_ch       (cfg_ch),
    .snap_valid_o (snap_valid),
    .snap_ready_i (snap_ready),
    .snap_o       (snap)
  );

  // Decimal split, pipelined behind the state
  atss_digits u_digits (
    .clk          (clk),
    .rst_n        (rst_n),
    .snap_valid_i (snap_valid),
    .snap_ready_o (snap_ready),
    .snap_i       (snap),
    .dig_valid_o  (dig_valid),
    .dig_ready_i  (dig_ready),
    .dig_o        (dig)
  );

  // Font and output register
  atss_render u_render (
    .clk         (clk),
    .rst_n       (rst_n),
    .dig_valid_i (dig_valid),
    .dig_ready_o (dig_ready),
    .dig_i       (dig),
    .out_ch      (out_ch)
  );

  // Exactly one digit is driven per result
  a_onehot_select: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> $onehot(out_ch.digit_select))
    else $error("digit_select not one-hot");

  // Decimal point sits on the second digit only
  a_dp_position: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.segments[0] == out_ch.digit_select[atss_pkg::POS_HUND]))
    else $error("decimal point on wrong digit");

  // Scaled value never reaches full scale
  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (32'(out_ch.shown_value) < atss_pkg::FULL_SCALE))
    else $error("shown_value out of range");

  // The split always yields a decimal digit for the hundreds and tens
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    dig_valid |-> (dig.q1 < 4'd10) && (dig.q2 < 4'd10))
    else $error("decimal split out of range");

endmodule

// File: rtl/atss_state.sv
// Registers, sample scaling, refresh and scan counters; emits a value/position snapshot.
module atss_state (
  input  logic              clk,
  input  logic              rst_n,
  atss_in_if.sink           in_ch,
  atss_cfg_if.sink          cfg_ch,
  output logic              snap_valid_o,
  input  logic              snap_ready_i,
  output atss_pkg::snap_t   snap_o
);

  atss_pkg::tick_t   refresh_ticks_r, dwell_ticks_r;
  atss_pkg::sample_t latest_r, latest_nxt;
  atss_pkg::value_t  shown_r, shown_nxt;
  logic              have_first_r, have_first_nxt;
  atss_pkg::tick_t   refresh_cnt_r, refresh_cnt_nxt;
  atss_pkg::tick_t   dwell_cnt_r, dwell_cnt_nxt;
  atss_pkg::pos_t    pos_r, pos_nxt;
  logic              snap_valid_r;

  logic                                      take;
  atss_pkg::sample_t                         scale_src;
  logic [atss_pkg::SAMPLE_BITS+16-1:0]       scale_prod;
  atss_pkg::value_t                          scaled;
  logic [atss_pkg::TICK_BITS:0]              refresh_inc, dwell_inc;
  logic                                      refresh_hit, dwell_hit;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !snap_valid_r || snap_ready_i;
  assign take         = in_ch.valid && in_ch.ready;

  // hundredths = raw * 50000 >> SAMPLE_BITS
  assign scale_src  = (in_ch.kind == atss_pkg::KIND_SAMPLE) ? in_ch.sample : latest_r;
  assign scale_prod = (atss_pkg::SAMPLE_BITS+16)'(scale_src)
                    * (atss_pkg::SAMPLE_BITS+16)'(atss_pkg::FULL_SCALE);
  assign scaled     = scale_prod[atss_pkg::SAMPLE_BITS +: atss_pkg::VALUE_BITS];

  assign refresh_inc = {1'b0, refresh_cnt_r} + 1'b1;
  assign dwell_inc   = {1'b0, dwell_cnt_r} + 1'b1;
  assign refresh_hit = refresh_inc >= {1'b0, refresh_ticks_r};
  assign dwell_hit   = dwell_inc >= {1'b0, dwell_ticks_r};

  always_comb begin
    latest_nxt      = latest_r;
    shown_nxt       = shown_r;
    have_first_nxt  = have_first_r;
    refresh_cnt_nxt = refresh_cnt_r;
    dwell_cnt_nxt   = dwell_cnt_r;
    pos_nxt         = pos_r;
    if (in_ch.kind == atss_pkg::KIND_SAMPLE) begin
      latest_nxt = in_ch.sample;
      if (!have_first_r) begin
        shown_nxt       = scaled;
        have_first_nxt  = 1'b1;
        refresh_cnt_nxt = '0;
      end
    end else begin
      // no refresh counting until the first sample
      if (have_first_r) begin
        if (refresh_hit) begin
          shown_nxt       = scaled;
          refresh_cnt_nxt = '0;
        end else begin
          refresh_cnt_nxt = refresh_inc[atss_pkg::TICK_BITS-1:0];
        end
      end
      if (dwell_hit) begin
        pos_nxt       = (pos_r == atss_pkg::pos_t'(atss_pkg::DIGIT_COUNT-1)) ? '0 : pos_r + 1'b1;
        dwell_cnt_nxt = '0;
      end else begin
        dwell_cnt_nxt = dwell_inc[atss_pkg::TICK_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refresh_ticks_r <= atss_pkg::REFRESH_RESET;
      dwell_ticks_r   <= atss_pkg::DWELL_RESET;
      latest_r        <= '0;
      shown_r         <= '0;
      have_first_r    <= 1'b0;
      refresh_cnt_r   <= '0;
      dwell_cnt_r     <= '0;
      pos_r           <= atss_pkg::POS_THOU;
      snap_valid_r    <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == atss_pkg::REG_REFRESH) begin
          refresh_ticks_r <= cfg_ch.data;
        end
        if (cfg_ch.index == atss_pkg::REG_DWELL) begin
          dwell_ticks_r <= cfg_ch.data;
        end
      end
      if (take) begin
        latest_r      <= latest_nxt;
        shown_r       <= shown_nxt;
        have_first_r  <= have_first_nxt;
        refresh_cnt_r <= refresh_cnt_nxt;
        dwell_cnt_r   <= dwell_cnt_nxt;
        pos_r         <= pos_nxt;
        snap_valid_r  <= 1'b1;
      end else if (snap_ready_i) begin
        snap_valid_r <= 1'b0;
      end
    end
  end

  assign snap_valid_o = snap_valid_r;
  assign snap_o       = '{value: shown_r, pos: pos_r};

endmodule

// File: rtl/atss_digits.sv
// Three-stage decimal split of the displayed value by reciprocal multiplies.
module atss_digits (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                snap_valid_i,
  output logic                snap_ready_o,
  input  atss_pkg::snap_t     snap_i,
  output logic                dig_valid_o,
  input  logic                dig_ready_i,
  output atss_pkg::digits_t   dig_o
);

  // stage 2: thousands
  logic                              s2_valid_r;
  atss_pkg::snap_t                   s2_snap_r;
  logic [atss_pkg::Q0_BITS-1:0]      s2_q0_r;
  // stage 3: hundreds
  logic                              s3_valid_r;
  atss_pkg::snap_t                   s3_snap_r;
  logic [atss_pkg::Q0_BITS-1:0]      s3_q0_r;
  logic [atss_pkg::REST_BITS-1:0]    s3_rest_r;
  logic [atss_pkg::BCD_BITS-1:0]     s3_q1_r;
  // stage 4: tens
  logic                              s4_valid_r;
  atss_pkg::digits_t                 s4_r;

  logic s2_ready, s3_ready, s4_ready;

  logic [32:0]                       thou_prod;
  logic [15:0]                       thou_back, rest_diff;
  logic [atss_pkg::REST_BITS-1:0]    rest;
  logic [15:0]                       hund_prod;
  logic [9:0]                        hund_back, r2_diff;
  logic [atss_pkg::R2_BITS-1:0]      r2;
  logic [13:0]                       ten_prod;

  assign s4_ready     = !s4_valid_r || dig_ready_i;
  assign s3_ready     = !s3_valid_r || s4_ready;
  assign s2_ready     = !s2_valid_r || s3_ready;
  assign snap_ready_o = s2_ready;

  assign thou_prod = 33'(snap_i.value) * 33'(atss_pkg::THOU_MUL);

  assign thou_back = 16'(s2_q0_r) * 16'(1000);
  assign rest_diff = s2_snap_r.value - thou_back;
  assign rest      = rest_diff[atss_pkg::REST_BITS-1:0];
  assign hund_prod = 16'(rest) * 16'(atss_pkg::HUND_MUL);

  assign hund_back = 10'(s3_q1_r) * 10'(100);
  assign r2_diff   = s3_rest_r - hund_back;
  assign r2        = r2_diff[atss_pkg::R2_BITS-1:0];
  assign ten_prod  = 14'(r2) * 14'(atss_pkg::TEN_MUL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_valid_r <= snap_valid_i;
      end
      if (s3_ready) begin
        s3_valid_r <= s2_valid_r;
      end
      if (s4_ready) begin
        s4_valid_r <= s3_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && snap_valid_i) begin
      s2_snap_r <= snap_i;
      s2_q0_r   <= thou_prod[atss_pkg::THOU_SHIFT +: atss_pkg::Q0_BITS];
    end
    if (s3_ready && s2_valid_r) begin
      s3_snap_r <= s2_snap_r;
      s3_q0_r   <= s2_q0_r;
      s3_rest_r <= rest;
      s3_q1_r   <= hund_prod[atss_pkg::HUND_SHIFT +: atss_pkg::BCD_BITS];
    end
    if (s4_ready && s3_valid_r) begin
      s4_r.value <= s3_snap_r.value;
      s4_r.pos   <= s3_snap_r.pos;
      s4_r.q0    <= s3_q0_r;
      s4_r.q1    <= s3_q1_r;
      s4_r.q2    <= ten_prod[atss_pkg::TEN_SHIFT +: atss_pkg::BCD_BITS];
      s4_r.r2    <= r2;
    end
  end

  assign dig_valid_o = s4_valid_r;
  assign dig_o       = s4_r;

endmodule

// File: rtl/atss_render.sv
// Glyph lookup for the scanned digit, digit enable and the result register.
module atss_render (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                dig_valid_i,
  output logic                dig_ready_o,
  input  atss_pkg::digits_t   dig_i,
  atss_out_if.source          out_ch
);

  logic                                out_valid_r;
  atss_pkg::seg_t                      seg_r, seg_nxt;
  logic [atss_pkg::DIGIT_COUNT-1:0]    sel_r, sel_nxt;
  atss_pkg::value_t                    value_r;

  logic [atss_pkg::R2_BITS-1:0]        ten_back, unit_diff;
  logic [atss_pkg::BCD_BITS-1:0]       units;

  assign dig_ready_o = !out_valid_r || out_ch.ready;

  assign ten_back  = atss_pkg::R2_BITS'(dig_i.q2) * atss_pkg::R2_BITS'(10);
  assign unit_diff = dig_i.r2 - ten_back;
  assign units     = unit_diff[atss_pkg::BCD_BITS-1:0];

  always_comb begin
    sel_nxt             = '0;
    sel_nxt[dig_i.pos]  = 1'b1;
    case (dig_i.pos)
      atss_pkg::POS_THOU: seg_nxt = atss_pkg::glyph(dig_i.q0);
      atss_pkg::POS_HUND: seg_nxt = atss_pkg::glyph(atss_pkg::Q0_BITS'(dig_i.q1))
                                    | atss_pkg::SEG_DP;
      atss_pkg::POS_TENS: seg_nxt = atss_pkg::glyph(atss_pkg::Q0_BITS'(dig_i.q2));
      default:            seg_nxt = atss_pkg::glyph(atss_pkg::Q0_BITS'(units));
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dig_ready_o) begin
      out_valid_r <= dig_valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (dig_ready_o && dig_valid_i) begin
      seg_r   <= seg_nxt;
      sel_r   <= sel_nxt;
      value_r <= dig_i.value;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.segments     = seg_r;
  assign out_ch.digit_select = sel_r;
  assign out_ch.shown_value  = value_r;

endmodule

// File: dv/atss_display_checker.sv
// Display scanner checker: predicts each result item from accepted inputs and compares it.
module atss_display_checker
  import atss_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  atss_in_if   in_mon,
  atss_out_if  out_mon,
  atss_cfg_if  cfg_mon,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    seg_t                   segments;
    logic [DIGIT_COUNT-1:0] digit_select;
    value_t                 shown_value;
  } display_t;

  // bit0 DP, bit1 C, bit2 D, bit3 E, bit4 B, bit5 A, bit6 F, bit7 G
  localparam seg_t FONT [10] = '{8'h7E, 8'h12, 8'hBC, 8'hB6, 8'hD2,
                                 8'hE6, 8'hCE, 8'h32, 8'hFE, 8'hF2};

  tick_t    refresh_period;
  tick_t    dwell_period;
  sample_t  last_sample;
  value_t   shown;
  logic     have_first;
  tick_t    refresh_cnt;
  tick_t    dwell_cnt;
  pos_t     scan_pos;
  display_t display_q [$];

  function automatic value_t to_hundredths(input sample_t s);
    return value_t'((int'(s) * FULL_SCALE) >> SAMPLE_BITS);
  endfunction

  // Advance the display state by one item and return what the glass shows after it.
  function automatic display_t advance_display(input logic k, input sample_t s);
    display_t r;
    int       q0;
    int       rest;
    if (k == KIND_SAMPLE) begin
      last_sample = s;
      if (!have_first) begin
        shown       = to_hundredths(last_sample);
        have_first  = 1'b1;
        refresh_cnt = '0;
      end
    end else begin
      // refresh counting only starts once a sample has been seen
      if (have_first) begin
        if ({1'b0, refresh_cnt} + 17'd1 >= {1'b0, refresh_period}) begin
          shown       = to_hundredths(last_sample);
          refresh_cnt = '0;
        end else begin
          refresh_cnt = refresh_cnt + 1'b1;
        end
      end
      if ({1'b0, dwell_cnt} + 17'd1 >= {1'b0, dwell_period}) begin
        scan_pos  = scan_pos + 1'b1;
        dwell_cnt = '0;
      end else begin
        dwell_cnt = dwell_cnt + 1'b1;
      end
    end
    q0   = int'(shown) / 1000;
    rest = int'(shown) % 1000;
    case (scan_pos)
      POS_THOU: r.segments = (q0 < 10) ? FONT[q0] : '0;  // blank above nine
      POS_HUND: r.segments = FONT[rest / 100] | SEG_DP;
      POS_TENS: r.segments = FONT[(rest / 10) % 10];
      default:  r.segments = FONT[rest % 10];
    endcase
    r.digit_select = {{(DIGIT_COUNT-1){1'b0}}, 1'b1} << scan_pos;
    r.shown_value  = shown;
    return r;
  endfunction

  always @(posedge clk) begin
    display_t want;
    int       errs;
    errs = 0;
    if (!rst_n) begin
      refresh_period = REFRESH_RESET;
      dwell_period   = DWELL_RESET;
      last_sample    = '0;
      shown          = '0;
      have_first     = 1'b0;
      refresh_cnt    = '0;
      dwell_cnt      = '0;
      scan_pos       = POS_THOU;
      display_q.delete();
      fail_count <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (display_q.size() == 0) begin
          $display("%0t: unexpected result item: segments %h digit_select %h shown_value %0d",
                   $time, out_mon.segments, out_mon.digit_select, out_mon.shown_value);
          errs++;
        end else begin
          want = display_q.pop_front();
          if (out_mon.segments !== want.segments) begin
            $display("%0t: segments mismatch: expected %h actual %h",
                     $time, want.segments, out_mon.segments);
            errs++;
          end
          if (out_mon.digit_select !== want.digit_select) begin
            $display("%0t: digit_select mismatch: expected %b actual %b",
                     $time, want.digit_select, out_mon.digit_select);
            errs++;
          end
          if (out_mon.shown_value !== want.shown_value) begin
            $display("%0t: shown_value mismatch: expected %0d actual %0d",
                     $time, want.shown_value, out_mon.shown_value);
            errs++;
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == REG_REFRESH) refresh_period = tick_t'(cfg_mon.data);
        else if (cfg_mon.index == REG_DWELL) dwell_period = tick_t'(cfg_mon.data);
      end
      if (in_mon.valid && in_mon.ready)
        display_q.push_back(advance_display(in_mon.kind, in_mon.sample));
      fail_count <= fail_count + errs;
    end
    pending <= display_q.size();
  end

endmodule

// File: dv/adc_temperature_seven_segment_scan_tb.sv
// Testbench top for the temperature display scanner: clock, reset, stimulus and verdict.
module adc_temperature_seven_segment_scan_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import atss_pkg::*;

  localparam int         WATCHDOG_LIMIT = 3000;  // cycles with no handshake at all
  localparam int         LONG_HOLD      = 60;    // well past the five pipe stages
  localparam int         PHASE_ITEMS    = 100;
  localparam cfg_index_t REG_UNUSED     = cfg_index_t'(2);  // no register here, dropped

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   pending;

  // sender / receiver behavior knobs
  int   tx_idle_pct;
  int   rx_stall_pct;
  logic rx_long_hold;
  int   hold_cnt;
  int   quiet_cycles;

  atss_in_if  in_if ();
  atss_out_if out_if ();
  atss_cfg_if cfg_if ();

  adc_temperature_seven_segment_scan dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  atss_display_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .cfg_mon    (cfg_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #10 clk = ~clk;

  // Result side. A one-shot long hold-off holds ready low until hold_cnt reaches LONG_HOLD
  // so the pipe fills and in_ch backs up; otherwise ready drops at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_cnt     <= 0;
    end else if (rx_long_hold && hold_cnt < LONG_HOLD) begin
      out_if.ready <= 1'b0;
      hold_cnt     <= hold_cnt + 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Watchdog: any handshake restarts the count; a stuck pipe or a lost
  // result item ends the run here.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one item, with random idle cycles ahead of it; returns at the accepting edge
  // with valid still high so back-to-back items need no re-raise.
  task automatic send_item(input logic k, input sample_t s);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.kind   <= k;
    in_if.sample <= s;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Mostly ticks, so the refresh and dwell counters actually roll over;
  // sample bits stay random on ticks too since the block must ignore them.
  task automatic random_item();
    logic k;
    k = ($urandom_range(99) < 65) ? KIND_TICK : KIND_SAMPLE;
    send_item(k, sample_t'($urandom));
  endtask

  // Stop offering and wait for every outstanding result item. The first edge
  // lets the checker count an item accepted at the edge we returned on.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_register(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  // Only called with the block drained.
  task automatic program_periods(input tick_t refresh, input tick_t dwell, input bit poke_unused);
    write_register(REG_REFRESH, refresh);
    write_register(REG_DWELL, dwell);
    if (poke_unused) write_register(REG_UNUSED, '1);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_phase(input tick_t refresh, input tick_t dwell, input int tx_pct,
                           input int rx_pct, input logic long_hold);
    drain();
    program_periods(refresh, dwell, 1'b0);
    tx_idle_pct = tx_pct;
    rx_stall_pct <= rx_pct;
    rx_long_hold <= long_hold;
    repeat (PHASE_ITEMS) random_item();
  endtask

  initial begin
    in_if.valid   <= 1'b0;
    in_if.kind    <= KIND_TICK;
    in_if.sample  <= '0;
    cfg_if.valid  <= 1'b0;
    cfg_if.index  <= REG_REFRESH;
    cfg_if.data   <= '0;
    rst_n         <= 1'b0;
    rx_stall_pct  <= 0;
    rx_long_hold  <= 1'b0;
    tx_idle_pct   = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset periods (refresh 500, dwell 1). Ticks before any sample move the
    // scan but leave the value at zero and refresh counting stopped.
    send_item(KIND_TICK, 10'h3FF);
    send_item(KIND_TICK, 10'h000);
    send_item(KIND_TICK, 10'h155);
    // First sample latches at once: full scale, thousands quotient far above nine
    send_item(KIND_SAMPLE, 10'h3FF);
    send_item(KIND_TICK, 10'h2AA);
    send_item(KIND_TICK, 10'h3FF);
    send_item(KIND_TICK, 10'h000);
    send_item(KIND_TICK, 10'h155);
    // Later samples wait for the refresh period
    send_item(KIND_SAMPLE, 10'h000);

    // Refresh on every tick; the write to a register that does not exist must be dropped.
    drain();
    program_periods(tick_t'(1), tick_t'(1), 1'b1);
    send_item(KIND_TICK, 10'h3FF);     // latches zero
    send_item(KIND_SAMPLE, 10'd205);   // just over 100 degrees: blank leftmost digit
    send_item(KIND_TICK, 10'h000);
    send_item(KIND_SAMPLE, 10'd204);   // just under 100 degrees
    send_item(KIND_TICK, 10'h000);
    send_item(KIND_SAMPLE, 10'd1);
    send_item(KIND_TICK, 10'h3FF);
    send_item(KIND_SAMPLE, 10'd512);
    send_item(KIND_TICK, 10'h000);

    // Random phases. Period zero acts as one. Large periods build up counts
    // that the following phase then cuts below, so the event fires on the
    // next tick. The long hold-off sits in the phase with the largest periods.
    run_phase(tick_t'(0),     tick_t'(0),     0,  0,  1'b0);
    run_phase(tick_t'(3),     tick_t'(2),     78, 0,  1'b0);
    run_phase(tick_t'(40),    tick_t'(30),    0,  78, 1'b0);
    run_phase(tick_t'(2),     tick_t'(2),     6,  6,  1'b0);
    run_phase(tick_t'(65535), tick_t'(65535), 0,  0,  1'b1);
    run_phase(tick_t'(65535), tick_t'(1),     78, 0,  1'b0);
    run_phase(tick_t'(7),     tick_t'(5),     0,  78, 1'b0);
    run_phase(tick_t'(500),   tick_t'(3),     6,  6,  1'b0);

    // Everything offered: let the pipe empty, then a few more cycles so a
    // stray extra result item would still be caught.
    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/atss_pkg.sv
rtl/atss_if.sv
rtl/atss_state.sv
rtl/atss_digits.sv
rtl/atss_render.sv
rtl/adc_temperature_seven_segment_scan.sv
dv/atss_display_checker.sv
dv/adc_temperature_seven_segment_scan_tb.sv
